/* hw/rtl/iprt_pkg.sv */
package iprt_pkg;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_COVERED  = 3'd1,
        ST_FULL     = 3'd2,
        ST_HIT      = 3'd3,
        ST_MISS     = 3'd4
    } t_status;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    localparam int unsigned AddrWidth  = 32;
    localparam int unsigned CountWidth = 7;
    localparam int unsigned CountMax   = 127;

endpackage

/* hw/rtl/iprt_mem.sv */
module iprt_mem #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = 6
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [AW-1:0]                    i_waddr,
    input  logic                             i_wvalid,
    input  logic [iprt_pkg::AddrWidth-1:0]   i_wstart,
    input  logic [iprt_pkg::AddrWidth-1:0]   i_wend,
    input  logic [AW-1:0]                    i_raddr,
    output logic                             o_rvalid,
    output logic [iprt_pkg::AddrWidth-1:0]   o_rstart,
    output logic [iprt_pkg::AddrWidth-1:0]   o_rend
);
    import iprt_pkg::*;

    // Each word holds the valid flag above the start and end addresses.
    logic [2*AddrWidth:0] mem [DEPTH];
    logic [2*AddrWidth:0] r_rdata;

    // Single write port, registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= {i_wvalid, i_wstart, i_wend};
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rvalid = r_rdata[2*AddrWidth];
    assign o_rstart = r_rdata[2*AddrWidth-1:AddrWidth];
    assign o_rend   = r_rdata[AddrWidth-1:0];
endmodule

/* hw/rtl/ip_range_table.sv */
// Range table: holds up to TABLE_DEPTH disjoint inclusive address ranges in one
// synchronous memory whose words carry a valid flag. Each request is handled by a
// sequencer that sweeps the memory one entry per cycle. A lookup takes one sweep.
// An insert takes up to three sweeps (start trim, end trim, then count and remove)
// and one write; an insert that is already covered ends after its first or second
// sweep. Ranges swallowed by an insert are invalidated during the last sweep. One
// request is handled at a time; the result waits in an output register while input
// ready is low, and the sequencer returns to idle after each taken result before the
// next request is accepted. After reset a clearing pass marks every entry free, with
// o_ready held low.
module ip_range_table #(
    parameter int unsigned TABLE_DEPTH = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_action,
    input  logic [iprt_pkg::AddrWidth-1:0]    i_start_addr,
    input  logic [iprt_pkg::AddrWidth-1:0]    i_end_addr,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [2:0]                        o_status,
    output logic [iprt_pkg::AddrWidth-1:0]    o_stored_start,
    output logic [iprt_pkg::AddrWidth-1:0]    o_stored_end,
    output logic [iprt_pkg::CountWidth-1:0]   o_removed_count
);
    import iprt_pkg::*;

    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_SCAN, S_DONE_SCAN, S_WRITE, S_OUT
    } t_state;
    typedef enum logic [1:0] {
        P_LOOK, P_START, P_END, P_SWEEP
    } t_phase;

    t_state r_state;
    t_phase r_phase;
    logic [AddrWidth-1:0] r_s, r_e;
    logic [AW:0]       r_idx;    // address issued to memory
    logic [AW-1:0]     r_cidx;   // index of the data now arriving
    logic              r_cvld;   // data arriving this cycle
    logic              r_found;
    logic [AddrWidth-1:0] r_hs, r_he;
    logic [CW-1:0]     r_used, r_swal;
    logic              r_free_found;
    logic [AW-1:0]     r_free;

    logic [2:0]        r_ostatus;
    logic [AddrWidth-1:0] r_os, r_oe;
    logic [CountWidth-1:0] r_orc;

    logic                 m_valid;
    logic [AddrWidth-1:0] m_start, m_end;
    logic                 w_we;
    logic                 w_wvalid;
    logic                 w_swal_wb;
    logic [AW-1:0]        w_raddr;
    logic [AW-1:0]        w_waddr;

    assign w_raddr = r_idx[AW-1:0];

    iprt_mem #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wvalid(w_wvalid),
        .i_wstart(r_s),
        .i_wend  (r_e),
        .i_raddr (w_raddr),
        .o_rvalid(m_valid),
        .o_rstart(m_start),
        .o_rend  (m_end)
    );

    // Compare helpers on the entry arriving from memory.
    logic c_vld, c_hold, c_swal;
    logic [AddrWidth-1:0] c_addr;
    logic [CW:0] c_rest;
    always_comb begin
        c_vld  = r_cvld && m_valid;
        c_addr = (r_phase == P_END) ? r_e : r_s;
        c_hold = c_vld && (m_start <= c_addr) && (c_addr <= m_end);
        c_swal = c_vld && (m_start >= r_s) && (m_start <= r_e);
        c_rest = {1'b0, r_used} - {1'b0, r_swal};
    end

    // Write port: clearing pass, removal of swallowed entries during the last sweep,
    // and the final store. Removal is safe before the full check, since a table with
    // any swallowed entry always has room for the new range.
    assign w_swal_wb = (r_state == S_SCAN) && (r_phase == P_SWEEP) && c_swal;
    assign w_we      = (r_state == S_CLEAR) || (r_state == S_WRITE) || w_swal_wb;
    assign w_wvalid  = (r_state == S_WRITE);
    always_comb begin
        case (r_state)
            S_CLEAR: w_waddr = r_idx[AW-1:0];
            S_WRITE: w_waddr = r_free;
            default: w_waddr = r_cidx;
        endcase
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_status = r_ostatus;
    assign o_stored_start = r_os;
    assign o_stored_end = r_oe;
    assign o_removed_count = r_orc;

    // Sequencer: sweeps the table for each phase of a request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_idx   <= '0;
            r_cvld  <= 1'b0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    if (r_idx == (AW+1)'(TABLE_DEPTH - 1)) begin
                        r_idx   <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        if (i_action == ACT_INSERT && i_start_addr > i_end_addr) begin
                            r_s <= i_end_addr;
                            r_e <= i_start_addr;
                        end else begin
                            r_s <= i_start_addr;
                            r_e <= i_end_addr;
                        end
                        r_phase <= (i_action == ACT_LOOKUP) ? P_LOOK : P_START;
                        r_idx   <= '0;
                        r_cvld  <= 1'b0;
                        r_found <= 1'b0;
                        r_used  <= '0;
                        r_swal  <= '0;
                        r_free_found <= 1'b0;
                        r_free  <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // Issue next address and consume the previous read.
                    r_cidx <= w_raddr;
                    r_cvld <= (r_idx < (AW+1)'(TABLE_DEPTH));
                    if (r_idx < (AW+1)'(TABLE_DEPTH)) begin
                        r_idx <= r_idx + 1'b1;
                    end
                    if (c_hold && !r_found && r_phase != P_SWEEP) begin
                        r_found <= 1'b1;
                        r_hs <= m_start;
                        r_he <= m_end;
                    end
                    if (r_phase == P_SWEEP && c_vld) begin
                        r_used <= r_used + 1'b1;
                        if (c_swal) begin
                            r_swal <= r_swal + 1'b1;
                        end
                    end
                    if (r_phase == P_SWEEP && r_cvld && !r_free_found &&
                        (!m_valid || c_swal)) begin
                        r_free_found <= 1'b1;
                        r_free <= r_cidx;
                    end
                    if (!r_cvld && r_idx == (AW+1)'(TABLE_DEPTH)) begin
                        r_state <= S_DONE_SCAN;
                    end
                end
                S_DONE_SCAN: begin
                    r_idx  <= '0;
                    r_cvld <= 1'b0;
                    r_found <= 1'b0;
                    case (r_phase)
                        P_LOOK: begin
                            r_ostatus <= r_found ? ST_HIT : ST_MISS;
                            r_os  <= r_found ? r_hs : '0;
                            r_oe  <= r_found ? r_he : '0;
                            r_orc <= '0;
                            r_state <= S_OUT;
                        end
                        P_START: begin
                            if (r_found && r_e <= r_he) begin
                                r_ostatus <= ST_COVERED;
                                r_os <= '0; r_oe <= '0; r_orc <= '0;
                                r_state <= S_OUT;
                            end else begin
                                if (r_found) r_s <= r_he + 1'b1;
                                r_phase <= P_END;
                                r_state <= S_SCAN;
                            end
                        end
                        P_END: begin
                            if (r_found && r_s >= r_hs) begin
                                r_ostatus <= ST_COVERED;
                                r_os <= '0; r_oe <= '0; r_orc <= '0;
                                r_state <= S_OUT;
                            end else begin
                                if (r_found) r_e <= r_hs - 1'b1;
                                r_phase <= P_SWEEP;
                                r_state <= S_SCAN;
                            end
                        end
                        default: begin
                            if (c_rest >= (CW+1)'(TABLE_DEPTH)) begin
                                r_ostatus <= ST_FULL;
                                r_os <= r_s; r_oe <= r_e; r_orc <= '0;
                                r_state <= S_OUT;
                            end else begin
                                r_ostatus <= ST_INSERTED;
                                r_os <= r_s; r_oe <= r_e;
                                r_orc <= (32'(r_swal) > CountMax) ? CountWidth'(CountMax)
                                                               : CountWidth'(r_swal);
                                r_state <= S_WRITE;
                            end
                        end
                    endcase
                end
                S_WRITE: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // A held result does not change until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_stored_start))
        else $error("result changed while stalled");
    // Never accept a request while a result is pending.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid))
        else $error("ready while result pending");
    // Covered and miss results carry zero ranges.
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_COVERED || o_status == ST_MISS) |->
        o_stored_start == '0 && o_removed_count == '0)
        else $error("nonzero payload on empty result");
endmodule

/* test/ip_range_table_tb.sv */
module ip_range_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import iprt_pkg::*;

    localparam int unsigned DEPTH = 64;

    typedef struct packed {
        t_status     status;
        logic [31:0] rng_start;
        logic [31:0] rng_end;
        logic [6:0]  removed;
    } t_range_result;

    typedef struct packed {
        logic          action;
        logic [31:0]   addr_a;
        logic [31:0]   addr_b;
        logic          typed;
        t_range_result want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_action = ACT_INSERT;
    logic [31:0] i_start_addr = '0;
    logic [31:0] i_end_addr = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [2:0]  o_status;
    logic [31:0] o_stored_start;
    logic [31:0] o_stored_end;
    logic [6:0]  o_removed_count;

    // Shadow copy of the range table.
    logic [31:0] tbl_start [DEPTH];
    logic [31:0] tbl_end [DEPTH];
    logic        tbl_used [DEPTH];

    t_range_result pending_q[$];
    int          err_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_off_req = 0;
    int          hold_off_left = 0;

    ip_range_table u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_action        (i_action),
        .i_start_addr    (i_start_addr),
        .i_end_addr      (i_end_addr),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_status        (o_status),
        .o_stored_start  (o_stored_start),
        .o_stored_end    (o_stored_end),
        .o_removed_count (o_removed_count)
    );

    always #2 i_clk = ~i_clk;

    // Index of the stored range that holds an address, or -1.
    function automatic int holder_of(logic [31:0] addr);
        for (int k = 0; k < DEPTH; k++) begin
            if (tbl_used[k] && tbl_start[k] <= addr && addr <= tbl_end[k]) begin
                return k;
            end
        end
        return -1;
    endfunction

    // Works out the result of one request and updates the shadow table.
    function automatic t_range_result apply_request(logic act, logic [31:0] a, logic [31:0] b);
        t_range_result r;
        logic [31:0] lo;
        logic [31:0] hi;
        int h;
        int occupied;
        int swallowed;
        int slot;
        r = '{ST_MISS, 32'd0, 32'd0, 7'd0};
        if (act == ACT_LOOKUP) begin
            h = holder_of(a);
            if (h >= 0) begin
                r = '{ST_HIT, tbl_start[h], tbl_end[h], 7'd0};
            end
            return r;
        end
        lo = (a > b) ? b : a;
        hi = (a > b) ? a : b;
        r = '{ST_COVERED, 32'd0, 32'd0, 7'd0};
        h = holder_of(lo);
        if (h >= 0) begin
            if (hi <= tbl_end[h]) begin
                return r;
            end
            lo = tbl_end[h] + 32'd1;
        end
        h = holder_of(hi);
        if (h >= 0) begin
            if (lo >= tbl_start[h]) begin
                return r;
            end
            hi = tbl_start[h] - 32'd1;
        end
        occupied = 0;
        swallowed = 0;
        for (int k = 0; k < DEPTH; k++) begin
            if (tbl_used[k]) begin
                occupied++;
                if (tbl_start[k] >= lo && tbl_start[k] <= hi) begin
                    swallowed++;
                end
            end
        end
        if (occupied - swallowed >= DEPTH) begin
            return '{ST_FULL, lo, hi, 7'd0};
        end
        for (int k = 0; k < DEPTH; k++) begin
            if (tbl_used[k] && tbl_start[k] >= lo && tbl_start[k] <= hi) begin
                tbl_used[k] = 1'b0;
            end
        end
        slot = 0;
        for (int k = DEPTH - 1; k >= 0; k--) begin
            if (!tbl_used[k]) begin
                slot = k;
            end
        end
        tbl_start[slot] = lo;
        tbl_end[slot] = hi;
        tbl_used[slot] = 1'b1;
        return '{ST_INSERTED, lo, hi, (swallowed > CountMax) ? 7'(CountMax) : 7'(swallowed)};
    endfunction

    // Offers one request, waits for acceptance and records what must come back.
    task automatic send_request(logic act, logic [31:0] a, logic [31:0] b,
                                logic typed, t_range_result want);
        t_range_result got;
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) begin
                @(posedge i_clk);
            end
        end
        i_valid <= 1'b1;
        i_action <= act;
        i_start_addr <= a;
        i_end_addr <= b;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
        got = apply_request(act, a, b);
        pending_q.push_back(typed ? want : got);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Random request: mostly small ranges around a few busy windows.
    task automatic random_request();
        logic [31:0] base;
        logic [31:0] a;
        logic [31:0] b;
        logic act;
        int pick;
        pick = $urandom_range(99);
        case ($urandom_range(2))
            0: base = 32'h0000_0000;
            1: base = 32'h8000_0000;
            default: base = 32'hFFFF_F800;
        endcase
        a = base + $urandom_range(2047);
        b = a + $urandom_range(40);
        act = ACT_INSERT;
        if (pick < 35) begin
            act = ACT_LOOKUP;
            b = $urandom();
        end else if (pick < 45) begin
            act = ($urandom_range(1) == 0) ? ACT_INSERT : ACT_LOOKUP;
            a = $urandom();
            b = a + $urandom_range(300);
        end else if (pick < 47) begin
            a = $urandom();
            b = $urandom();
        end
        if ($urandom_range(4) == 0) begin
            send_request(act, b, a, 1'b0, '0);
        end else begin
            send_request(act, a, b, 1'b0, '0);
        end
    endtask

    // Result side: random stalls, plus a long hold-off on request.
    always @(posedge i_clk) begin
        if (hold_off_req != 0) begin
            hold_off_left = hold_off_req;
            hold_off_req = 0;
        end
        if (hold_off_left > 0) begin
            hold_off_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Result checker.
    always @(posedge i_clk) begin
        t_range_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_q.size() == 0) begin
                err_count++;
                if (err_count <= 10) begin
                    $display("unexpected result: status %0d", o_status);
                end
            end else begin
                want = pending_q.pop_front();
                if (o_status !== want.status || o_stored_start !== want.rng_start
                    || o_stored_end !== want.rng_end || o_removed_count !== want.removed) begin
                    err_count++;
                    if (err_count <= 10) begin
                        $display("mismatch: expected %s %h..%h rm %0d, got %0d %h..%h rm %0d",
                                 want.status.name(), want.rng_start, want.rng_end,
                                 want.removed, o_status, o_stored_start, o_stored_end,
                                 o_removed_count);
                    end
                end
            end
        end
    end

    initial begin
        #4_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        t_row rows [17];
        rows = '{
            '{ACT_LOOKUP, 32'd0, 32'd0, 1'b1, '{ST_MISS, 32'd0, 32'd0, 7'd0}},
            '{ACT_INSERT, 32'd100, 32'd200, 1'b1, '{ST_INSERTED, 32'd100, 32'd200, 7'd0}},
            '{ACT_INSERT, 32'd300, 32'd250, 1'b1, '{ST_INSERTED, 32'd250, 32'd300, 7'd0}},
            '{ACT_INSERT, 32'd150, 32'd180, 1'b1, '{ST_COVERED, 32'd0, 32'd0, 7'd0}},
            '{ACT_INSERT, 32'd150, 32'd260, 1'b1, '{ST_INSERTED, 32'd201, 32'd249, 7'd0}},
            '{ACT_LOOKUP, 32'd210, 32'hFFFF_FFFF, 1'b1, '{ST_HIT, 32'd201, 32'd249, 7'd0}},
            '{ACT_LOOKUP, 32'd5000, 32'd0, 1'b1, '{ST_MISS, 32'd0, 32'd0, 7'd0}},
            '{ACT_INSERT, 32'd50, 32'd400, 1'b1, '{ST_INSERTED, 32'd50, 32'd400, 7'd3}},
            '{ACT_LOOKUP, 32'd256, 32'd0, 1'b1, '{ST_HIT, 32'd50, 32'd400, 7'd0}},
            '{ACT_INSERT, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 1'b1,
              '{ST_INSERTED, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 7'd0}},
            '{ACT_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{ST_COVERED, 32'd0, 32'd0, 7'd0}},
            '{ACT_LOOKUP, 32'hFFFF_FFFF, 32'd0, 1'b1,
              '{ST_HIT, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 7'd0}},
            '{ACT_INSERT, 32'd0, 32'd0, 1'b1, '{ST_INSERTED, 32'd0, 32'd0, 7'd0}},
            '{ACT_INSERT, 32'd60, 32'd0, 1'b1, '{ST_INSERTED, 32'd1, 32'd49, 7'd0}},
            '{ACT_INSERT, 32'd30, 32'd450, 1'b0, '0},
            '{ACT_INSERT, 32'hFFFF_FF00, 32'hFFFF_FFF5, 1'b0, '0},
            '{ACT_LOOKUP, 32'd0, 32'd0, 1'b1, '{ST_HIT, 32'd0, 32'd0, 7'd0}}
        };
        for (int k = 0; k < DEPTH; k++) begin
            tbl_start[k] = '0;
            tbl_end[k] = '0;
            tbl_used[k] = 1'b0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table.
        foreach (rows[k]) begin
            send_request(rows[k].action, rows[k].addr_a, rows[k].addr_b,
                         rows[k].typed, rows[k].want);
        end
        drain_results();

        // Random phases with different idle patterns.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
                default: begin send_idle_pct = 30; recv_stall_pct = 30; end
            endcase
            if (phase == 2) begin
                hold_off_req = 1500;
            end
            if (phase == 3) begin
                // Pack small ranges until the table overflows, then swallow a block.
                for (int k = 0; k < 70; k++) begin
                    send_request(ACT_INSERT, 32'h4000_0000 + 8 * k, 32'h4000_0003 + 8 * k,
                                 1'b0, '0);
                end
                send_request(ACT_INSERT, 32'h4000_0000, 32'h4000_0100, 1'b0, '0);
            end
            for (int n = 0; n < 130; n++) begin
                random_request();
            end
            // Sender pauses until everything outstanding has come back.
            drain_results();
        end

        repeat (400) @(posedge i_clk);
        if (err_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

/* ip_range_table.f */
hw/rtl/iprt_pkg.sv
hw/rtl/iprt_mem.sv
hw/rtl/ip_range_table.sv
test/ip_range_table_tb.sv
